/* rtl/ambient_light_lux_calc_assert.svh */
// Assertion macros shared by the lux calculator RTL.
// Depends on nothing; included inside module bodies.
`ifndef AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lux calculator: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ALC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lux calculator: next-cycle check failed");

`endif

/* rtl/alc_pkg.sv */
// Package for the lux calculator: widths, register codes, timing constants
// and the breakpoint coefficient tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alc_pkg;

    localparam int COUNT_W    = 16;
    localparam int SCALE_W    = 19;
    localparam int CH_SHIFT   = 10;
    localparam int CH_W       = 22;
    localparam int Q_W        = 11;
    localparam int RATIO_W    = 11;
    localparam int COEF_W     = 10;
    localparam int PROD_W     = 32;
    localparam int LUX_SHIFT  = 14;
    localparam int LUX_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam int TAB_ROWS   = 7;

    // Ten quotient bits after the first, two per divider stage.
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (Q_W - 1) / DIV_PER_STAGE;

    localparam logic [CFG_IDX_W-1:0] REG_ITIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PKG   = 2'd2;

    localparam logic [1:0] ITIME_13MS  = 2'd0;
    localparam logic [1:0] ITIME_101MS = 2'd1;
    localparam logic [1:0] ITIME_402MS = 2'd2;

    localparam logic [COUNT_W-1:0] CLIP_13MS  = 16'd4900;
    localparam logic [COUNT_W-1:0] CLIP_101MS = 16'd37000;
    localparam logic [COUNT_W-1:0] CLIP_402MS = 16'd65000;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00FE7;
    localparam logic [SCALE_W-1:0] SCALE_402MS = 19'h00400;

    localparam logic [LUX_W-1:0] SAT_LUX = 18'd65536;

    typedef struct packed {
        logic [COEF_W-1:0] bp;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } t_coef_row;

    typedef struct packed {
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } t_coef_pair;

    localparam t_coef_row TAB_T [TAB_ROWS] = '{
        '{10'h040, 10'h1f2, 10'h1be},
        '{10'h080, 10'h214, 10'h2d1},
        '{10'h0c0, 10'h23f, 10'h37b},
        '{10'h100, 10'h270, 10'h3fe},
        '{10'h138, 10'h16f, 10'h1fc},
        '{10'h19a, 10'h0d2, 10'h0fb},
        '{10'h29a, 10'h018, 10'h012}
    };

    localparam t_coef_row TAB_CS [TAB_ROWS] = '{
        '{10'h043, 10'h204, 10'h1ad},
        '{10'h085, 10'h228, 10'h2c1},
        '{10'h0c8, 10'h253, 10'h363},
        '{10'h10a, 10'h282, 10'h3df},
        '{10'h14d, 10'h177, 10'h1dd},
        '{10'h19a, 10'h101, 10'h127},
        '{10'h29a, 10'h037, 10'h02b}
    };

    // First row whose breakpoint is not below the ratio; zero when none
    // matches or the ratio is known to be out of range.
    function automatic t_coef_pair coef_select(input logic cs,
                                               input logic [RATIO_W-1:0] ratio,
                                               input logic over);
        t_coef_pair res;
        t_coef_row  row;
        logic       found;
        res   = '0;
        found = 1'b0;
        for (int i = 0; i < TAB_ROWS; i++) begin
            row = cs ? TAB_CS[i] : TAB_T[i];
            if (!found && !over && (ratio <= {1'b0, row.bp})) begin
                res.b = row.b;
                res.m = row.m;
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/ambient_light_lux_calc.sv */
// Top level of the two-channel photodiode lux calculator, fully pipelined.
// Depends on alc_pkg and ambient_light_lux_calc_assert.svh.
//
// Channel   Handshake                       Payload
// input     start && !busy                  i_broadband_count, i_infrared_count
// result    o_strobe (one cycle)            o_lux, o_saturated
// config    i_cfg_valid && o_cfg_ready      i_cfg_index, i_cfg_data
//
// One item is taken every cycle; busy stays low and o_cfg_ready stays high.
// A result passes in order through the register stages: input, channel scaling,
// divider set-up, five divider stages of two quotient bits each, coefficient
// lookup, coefficient multiply and output.
// Reset is synchronous and clears the valid bits and configuration only.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module ambient_light_lux_calc (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [alc_pkg::COUNT_W-1:0]       i_broadband_count,
    input  wire  [alc_pkg::COUNT_W-1:0]       i_infrared_count,
    output logic                              o_strobe,
    output logic [alc_pkg::LUX_W-1:0]         o_lux,
    output logic                              o_saturated,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [alc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [alc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import alc_pkg::*;

    `include "ambient_light_lux_calc_assert.svh"

    typedef struct packed {
        logic            v;
        logic            sat;
        logic            cs;
        logic            zero;
        logic            over;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] rem;
        logic [Q_W-1:0]  q;
    } t_div;

    // Configuration registers
    logic [1:0] r_itime;
    logic       r_high_gain;
    logic       r_pkg_cs;

    logic accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_itime     <= ITIME_402MS;
            r_high_gain <= 1'b0;
            r_pkg_cs    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ITIME: r_itime     <= i_cfg_data;
                REG_GAIN:  r_high_gain <= i_cfg_data[0];
                REG_PKG:   r_pkg_cs    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage 1: clip check and scale selection
    logic [COUNT_W-1:0] clip;
    logic [SCALE_W-1:0] scale_base;
    logic [SCALE_W-1:0] n_s1_scale;

    always_comb begin
        unique case (r_itime)
            ITIME_13MS: begin
                clip       = CLIP_13MS;
                scale_base = SCALE_13MS;
            end
            ITIME_101MS: begin
                clip       = CLIP_101MS;
                scale_base = SCALE_101MS;
            end
            default: begin
                clip       = CLIP_402MS;
                scale_base = SCALE_402MS;
            end
        endcase
        n_s1_scale = r_high_gain ? scale_base : {scale_base[SCALE_W-5:0], 4'b0000};
    end

    logic               r_s1_v;
    logic               r_s1_sat;
    logic               r_s1_cs;
    logic [COUNT_W-1:0] r_s1_bb;
    logic [COUNT_W-1:0] r_s1_ir;
    logic [SCALE_W-1:0] r_s1_scale;

    always_ff @(posedge i_clk) begin
        r_s1_v     <= i_rst_n && accept;
        r_s1_sat   <= (i_broadband_count > clip) || (i_infrared_count > clip);
        r_s1_cs    <= r_pkg_cs;
        r_s1_bb    <= i_broadband_count;
        r_s1_ir    <= i_infrared_count;
        r_s1_scale <= n_s1_scale;
    end

    // Stage 2: scale both channels
    logic [COUNT_W+SCALE_W-1:0] prod0;
    logic [COUNT_W+SCALE_W-1:0] prod1;

    assign prod0 = r_s1_bb * r_s1_scale;
    assign prod1 = r_s1_ir * r_s1_scale;

    logic            r_s2_v;
    logic            r_s2_sat;
    logic            r_s2_cs;
    logic [CH_W-1:0] r_s2_ch0;
    logic [CH_W-1:0] r_s2_ch1;

    always_ff @(posedge i_clk) begin
        r_s2_v   <= i_rst_n && r_s1_v;
        r_s2_sat <= r_s1_sat;
        r_s2_cs  <= r_s1_cs;
        r_s2_ch0 <= prod0[CH_W+CH_SHIFT-1:CH_SHIFT];
        r_s2_ch1 <= prod1[CH_W+CH_SHIFT-1:CH_SHIFT];
    end

    // Divider set-up: the quotient ch1*1024/ch0 only matters below 2048, so
    // ch1 >= 2*ch0 is flagged as out of range and the top bit comes first.
    t_div r_div [DIV_STAGES+1];
    t_div n_div0;

    always_comb begin
        logic ge;
        ge          = r_s2_ch1 >= r_s2_ch0;
        n_div0.v    = i_rst_n && r_s2_v;
        n_div0.sat  = r_s2_sat;
        n_div0.cs   = r_s2_cs;
        n_div0.zero = r_s2_ch0 == '0;
        n_div0.over = {1'b0, r_s2_ch1} >= {r_s2_ch0, 1'b0};
        n_div0.ch0  = r_s2_ch0;
        n_div0.ch1  = r_s2_ch1;
        n_div0.rem  = ge ? r_s2_ch1 - r_s2_ch0 : r_s2_ch1;
        n_div0.q    = {{(Q_W-1){1'b0}}, ge};
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= n_div0;
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_div n_div;

        always_comb begin : p_step
            logic [CH_W:0] t;
            n_div   = r_div[j];
            n_div.v = i_rst_n && r_div[j].v;
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
                t = {n_div.rem, 1'b0};
                if (t >= {1'b0, r_div[j].ch0}) begin
                    n_div.rem = CH_W'(t - {1'b0, r_div[j].ch0});
                    n_div.q   = {n_div.q[Q_W-2:0], 1'b1};
                end else begin
                    n_div.rem = t[CH_W-1:0];
                    n_div.q   = {n_div.q[Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[j+1] <= n_div;
        end
    end

    // Lookup stage: round the ratio and pick the coefficient pair.
    logic [Q_W:0]       q_inc;
    logic [RATIO_W-1:0] ratio;
    t_coef_pair         coef;

    always_comb begin
        q_inc = {1'b0, r_div[DIV_STAGES].q} + (Q_W+1)'(1);
        ratio = r_div[DIV_STAGES].zero ? '0 : q_inc[RATIO_W:1];
        coef  = coef_select(r_div[DIV_STAGES].cs, ratio,
                            r_div[DIV_STAGES].over && !r_div[DIV_STAGES].zero);
    end

    logic              r_l_v;
    logic              r_l_sat;
    logic [CH_W-1:0]   r_l_ch0;
    logic [CH_W-1:0]   r_l_ch1;
    logic [COEF_W-1:0] r_l_b;
    logic [COEF_W-1:0] r_l_m;

    always_ff @(posedge i_clk) begin
        r_l_v   <= i_rst_n && r_div[DIV_STAGES].v;
        r_l_sat <= r_div[DIV_STAGES].sat;
        r_l_ch0 <= r_div[DIV_STAGES].ch0;
        r_l_ch1 <= r_div[DIV_STAGES].ch1;
        r_l_b   <= coef.b;
        r_l_m   <= coef.m;
    end

    // Multiply stage
    logic              r_m_v;
    logic              r_m_sat;
    logic [PROD_W-1:0] r_m_pos;
    logic [PROD_W-1:0] r_m_neg;

    always_ff @(posedge i_clk) begin
        r_m_v   <= i_rst_n && r_l_v;
        r_m_sat <= r_l_sat;
        r_m_pos <= r_l_ch0 * r_l_b;
        r_m_neg <= r_l_ch1 * r_l_m;
    end

    // Output stage: clamp at zero, round and drop the fraction, or give SAT_LUX when saturated.
    logic [PROD_W-1:0] diff;
    logic [PROD_W:0]   acc;
    logic [LUX_W-1:0]  n_lux;

    always_comb begin
        diff  = (r_m_pos >= r_m_neg) ? r_m_pos - r_m_neg : '0;
        acc   = {1'b0, diff} + ((PROD_W+1)'(1) << (LUX_SHIFT - 1));
        n_lux = r_m_sat ? SAT_LUX : acc[LUX_SHIFT+LUX_W-1:LUX_SHIFT];
    end

    logic             r_strobe;
    logic [LUX_W-1:0] r_lux;
    logic             r_saturated;

    always_ff @(posedge i_clk) begin
        r_strobe    <= i_rst_n && r_m_v;
        r_lux       <= n_lux;
        r_saturated <= r_m_sat;
    end

    assign o_strobe    = r_strobe;
    assign o_lux       = r_lux;
    assign o_saturated = r_saturated;

    // Last divider stage and its two cases, as seen by the checks below.
    t_div div_last;
    logic div_in_range;
    logic div_over;

    assign div_last     = r_div[DIV_STAGES];
    assign div_in_range = div_last.v && !div_last.over && !div_last.zero;
    assign div_over     = div_last.v && div_last.over && !div_last.zero;

    `ALC_ASSERT_IMP(a_sat_lux, i_clk, i_rst_n, o_strobe && o_saturated, o_lux == SAT_LUX)
    `ALC_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, div_in_range, div_last.rem < div_last.ch0)
    `ALC_ASSERT_NXT(a_over_zero_coef, i_clk, i_rst_n, div_over, r_l_b == '0 && r_l_m == '0)
    `ALC_ASSERT_NXT(a_mul_to_out, i_clk, i_rst_n, r_m_v, o_strobe)

endmodule

`default_nettype wire
